// ===== sv/rbrk2_pkg.sv =====
// Shared types and constants of the rigid-body midpoint integrator.
package rbrk2_pkg;

    localparam int WORD_W  = 32;
    localparam int STATE_W = 48;
    localparam int MAG_W   = 57;

    typedef logic signed [WORD_W-1:0]  t_torque;
    typedef logic        [WORD_W-1:0]  t_word;
    typedef logic signed [STATE_W-1:0] t_state;
    typedef logic        [1:0]         t_cfg_idx;

    // Register indexes of the configuration port.
    localparam t_cfg_idx CFG_INERTIA_X = 2'd0;
    localparam t_cfg_idx CFG_INERTIA_Y = 2'd1;
    localparam t_cfg_idx CFG_INERTIA_Z = 2'd2;

    // Reset values of the inertia registers, unsigned Q4.28.
    localparam t_word INERTIA_X_RST = 32'd2684355;
    localparam t_word INERTIA_Y_RST = 32'd2684355;
    localparam t_word INERTIA_Z_RST = 32'd1342177;

    // Signed Q16.32 limits and the matching magnitude limits.
    localparam t_state STATE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_state STATE_MIN = 48'sh8000_0000_0000;
    localparam logic [MAG_W-1:0] MAG_POS_LIM = 57'h7FFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0] MAG_NEG_LIM = 57'h8000_0000_0000;

    // Divider: quotient bits resolved per cycle and divider steps per quotient.
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = STATE_W / DIV_BITS;
    typedef logic [4:0] t_div_cnt;

endpackage

// ===== sv/rbrk2_in_if.sv =====
// Input channel of the integrator: torque per axis and time step.
interface rbrk2_in_if;
    import rbrk2_pkg::*;

    logic    valid;
    logic    ready;
    t_torque torque_x;
    t_torque torque_y;
    t_torque torque_z;
    t_word   step_time;

    modport source (output valid, output torque_x, output torque_y, output torque_z,
                    output step_time, input ready);
    modport sink   (input valid, input torque_x, input torque_y, input torque_z,
                    input step_time, output ready);
endinterface

// ===== sv/rbrk2_out_if.sv =====
// Result channel of the integrator: new attitude, new rate and clamp flag.
interface rbrk2_out_if;
    import rbrk2_pkg::*;

    logic   valid;
    logic   ready;
    t_state angle_x;
    t_state angle_y;
    t_state angle_z;
    t_state spin_x;
    t_state spin_y;
    t_state spin_z;
    logic   saturated;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    output spin_x, output spin_y, output spin_z, output saturated,
                    input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    input spin_x, input spin_y, input spin_z, input saturated,
                    output ready);
endinterface

// ===== sv/rigid_body_rk2_step.sv =====
// Top level: three-axis rigid-body midpoint (RK2) step on a shared divider and multiplier.
//
//   channel   direction  width            transfer when
//   i_cmd     in         3x32 + 32        i_cmd.valid && i_cmd.ready
//   o_res     out        6x48 + 1         o_res.valid && o_res.ready
//   i_cfg_*   in         2 idx, 32 data   i_cfg_we high
//
// Each item runs, per axis, a setup step, the two-bit-per-cycle restoring divider, a sign
// step and three passes through the shared 32x32 multiplier, then a done step that loads
// the result register. Each multiplier pass sets up, multiplies low and high, rounds and adds.
// Reset (synchronous, active low) zeroes the state and loads the default inertias.
// i_cmd.ready is high only while the sequencer is idle; the done cycle stretches while
// an earlier result still waits in the output register.
module rigid_body_rk2_step #(
    parameter int AXIS_COUNT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbrk2_in_if.sink              i_cmd,
    rbrk2_out_if.source           o_res,
    input  logic                  i_cfg_we,
    input  rbrk2_pkg::t_cfg_idx   i_cfg_idx,
    input  rbrk2_pkg::t_word      i_cfg_data
);
    import rbrk2_pkg::*;

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_LOAD = 10'b00_0000_0010,
        S_DIV  = 10'b00_0000_0100,
        S_ACC  = 10'b00_0000_1000,
        S_MSET = 10'b00_0001_0000,
        S_MLO  = 10'b00_0010_0000,
        S_MHI  = 10'b00_0100_0000,
        S_RND  = 10'b00_1000_0000,
        S_ADD  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_seq;

    // Which of the three products is in the multiplier.
    typedef enum logic [1:0] {
        PH_HALF = 2'd0,   // half step times acceleration, gives the midpoint rate
        PH_FULL = 2'd1,   // full step times acceleration, gives the new rate
        PH_ANG  = 2'd2    // full step times midpoint rate, gives the new angle
    } t_phase;

    typedef struct packed {
        t_state value;
        logic   clamp;
    } t_sat;

    // Applies a sign to a magnitude and clamps to the signed Q16.32 range.
    function automatic t_sat sat_sign(input logic neg, input logic [MAG_W-1:0] mag);
        t_sat res;
        res.clamp = 1'b0;
        if (neg) begin
            if (mag > MAG_NEG_LIM) begin
                res.clamp = 1'b1;
                res.value = STATE_MIN;
            end else begin
                res.value = $signed(~mag[STATE_W-1:0] + 48'd1);
            end
        end else begin
            if (mag > MAG_POS_LIM) begin
                res.clamp = 1'b1;
                res.value = STATE_MAX;
            end else begin
                res.value = $signed(mag[STATE_W-1:0]);
            end
        end
        return res;
    endfunction

    // Saturating add of two Q16.32 values.
    function automatic t_sat add_sat(input t_state a, input t_state b);
        t_sat       res;
        logic [STATE_W:0] s;
        s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
        res.clamp = (s[STATE_W] != s[STATE_W-1]);
        if (res.clamp) begin
            res.value = s[STATE_W] ? STATE_MIN : STATE_MAX;
        end else begin
            res.value = $signed(s[STATE_W-1:0]);
        end
        return res;
    endfunction

    // Control registers.
    t_seq     r_state, n_state;
    logic [AW-1:0] r_axis;
    t_phase   r_phase;
    t_div_cnt r_cnt;
    logic     r_out_valid;
    t_word    r_inertia [3];
    t_state   r_angle [AXIS_COUNT];
    t_state   r_spin  [AXIS_COUNT];

    // Datapath registers.
    t_torque  r_torque [3];
    t_word    r_dt;
    t_word    r_div_d;
    logic [WORD_W-1:0]  r_rem;
    logic [STATE_W-1:0] r_dq;
    logic     r_div_ovf;
    logic     r_zero;
    logic     r_neg;
    t_state   r_accel;
    t_state   r_mid;
    logic [STATE_W-1:0] r_mag;
    logic [79:0] r_acc;
    t_state   r_term;
    logic     r_flag;
    t_state   r_out_angle [3];
    t_state   r_out_spin  [3];
    logic     r_out_sat;

    logic     cmd_xfer;
    logic     out_load;
    logic     last_axis;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign last_axis   = (r_axis == AW'(AXIS_COUNT - 1));

    // Setup of one division: |torque| * 2^32 + inertia / 2 over inertia. The low
    // word of the dividend is just inertia / 2, and the quotient overflows 48 bits
    // exactly when the top 16 dividend bits reach the divisor.
    t_torque  sel_torque;
    t_word    sel_inertia;
    t_word    sel_mag;
    always_comb begin
        sel_torque  = r_torque[r_axis];
        sel_inertia = r_inertia[r_axis];
        sel_mag     = sel_torque[WORD_W-1] ? (~sel_torque + 32'd1) : sel_torque;
    end

    // Restoring divider, DIV_BITS quotient bits per cycle; quotient bits shift
    // into the bottom of the dividend register.
    logic [WORD_W-1:0]  n_rem;
    logic [STATE_W-1:0] n_dq;
    always_comb begin
        logic [WORD_W:0] trial;
        n_rem = r_rem;
        n_dq  = r_dq;
        for (int j = 0; j < DIV_BITS; j++) begin
            trial = {n_rem, n_dq[STATE_W-1]};
            n_dq  = {n_dq[STATE_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div_d}) begin
                n_rem   = WORD_W'(trial - {1'b0, r_div_d});
                n_dq[0] = 1'b1;
            end else begin
                n_rem = trial[WORD_W-1:0];
            end
        end
    end

    // Shared multiplier: low 32 bits of the magnitude, then its upper 16 bits.
    logic [WORD_W-1:0] mul_a;
    logic [63:0]       prod;
    always_comb begin
        mul_a = (r_state == S_MLO) ? r_mag[WORD_W-1:0] : {16'd0, r_mag[STATE_W-1:WORD_W]};
        prod  = {32'd0, mul_a} * {32'd0, r_dt};
    end

    // Quotient to signed acceleration.
    t_sat acc_res;
    always_comb begin
        if (r_zero) begin
            acc_res.value = '0;
            acc_res.clamp = 1'b0;
        end else if (r_div_ovf) begin
            acc_res.value = r_neg ? STATE_MIN : STATE_MAX;
            acc_res.clamp = 1'b1;
        end else begin
            acc_res = sat_sign(r_neg, {9'd0, r_dq});
        end
    end

    // Round to nearest, ties away from zero, by 25 bits for the half step and 24 bits otherwise.
    logic [80:0]      rnd_sum;
    logic [MAG_W-1:0] rnd_mag;
    t_sat             rnd_res;
    always_comb begin
        if (r_phase == PH_HALF) begin
            rnd_sum = {1'b0, r_acc} + (81'd1 << 24);
            rnd_mag = {1'b0, rnd_sum[80:25]};
        end else begin
            rnd_sum = {1'b0, r_acc} + (81'd1 << 23);
            rnd_mag = rnd_sum[80:24];
        end
        rnd_res = sat_sign(r_neg, rnd_mag);
    end

    // Accumulating the product term into rate or angle.
    t_state mul_op;
    t_sat   add_res;
    always_comb begin
        mul_op  = (r_phase == PH_ANG) ? r_mid : r_accel;
        add_res = add_sat((r_phase == PH_ANG) ? r_angle[r_axis] : r_spin[r_axis], r_term);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (cmd_xfer) n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV:  if (r_cnt == t_div_cnt'(DIV_STEPS - 1)) n_state = S_ACC;
            S_ACC:  n_state = S_MSET;
            S_MSET: n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_RND;
            S_RND:  n_state = S_ADD;
            S_ADD: begin
                if (r_phase != PH_ANG) begin
                    n_state = S_MSET;
                end else if (last_axis) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and integrator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_axis       <= '0;
            r_phase      <= PH_HALF;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_inertia[0] <= INERTIA_X_RST;
            r_inertia[1] <= INERTIA_Y_RST;
            r_inertia[2] <= INERTIA_Z_RST;
            for (int k = 0; k < AXIS_COUNT; k++) begin
                r_angle[k] <= '0;
                r_spin[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INERTIA_X: r_inertia[0] <= i_cfg_data;
                    CFG_INERTIA_Y: r_inertia[1] <= i_cfg_data;
                    CFG_INERTIA_Z: r_inertia[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cmd_xfer) begin
                r_axis <= '0;
            end
            if (r_state == S_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + t_div_cnt'(1);
            end
            if (r_state == S_ACC) begin
                r_phase <= PH_HALF;
            end
            if (r_state == S_ADD) begin
                unique case (r_phase)
                    PH_HALF: r_phase <= PH_FULL;
                    PH_FULL: begin
                        r_phase         <= PH_ANG;
                        r_spin[r_axis]  <= add_res.value;
                    end
                    PH_ANG: begin
                        r_angle[r_axis] <= add_res.value;
                        if (!last_axis) r_axis <= r_axis + AW'(1);
                    end
                    default: r_phase <= PH_HALF;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Unused axes report zero.
    t_state fin_angle [3];
    t_state fin_spin  [3];
    for (genvar g = 0; g < 3; g++) begin : g_fin
        if (g < AXIS_COUNT) begin : g_used
            assign fin_angle[g] = r_angle[g];
            assign fin_spin[g]  = r_spin[g];
        end else begin : g_unused
            assign fin_angle[g] = '0;
            assign fin_spin[g]  = '0;
        end
    end

    // Datapath registers; none of them needs a reset.
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_torque[0] <= i_cmd.torque_x;
            r_torque[1] <= i_cmd.torque_y;
            r_torque[2] <= i_cmd.torque_z;
            r_dt        <= i_cmd.step_time;
            r_flag      <= 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                r_div_d   <= sel_inertia;
                r_rem     <= {16'd0, sel_mag[WORD_W-1:16]};
                r_dq      <= {sel_mag[15:0], 1'b0, sel_inertia[WORD_W-1:1]};
                r_div_ovf <= ({16'd0, sel_mag[WORD_W-1:16]} >= sel_inertia);
                r_zero    <= (sel_mag == '0);
                r_neg     <= sel_torque[WORD_W-1];
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_dq  <= n_dq;
            end
            S_ACC: begin
                r_accel <= acc_res.value;
                if (acc_res.clamp) r_flag <= 1'b1;
            end
            S_MSET: begin
                r_neg <= mul_op[STATE_W-1];
                r_mag <= mul_op[STATE_W-1] ? (~mul_op + 48'd1) : mul_op;
            end
            S_MLO:  r_acc <= {16'd0, prod};
            S_MHI:  r_acc <= r_acc + {prod[47:0], 32'd0};
            S_RND: begin
                r_term <= rnd_res.value;
                if (rnd_res.clamp) r_flag <= 1'b1;
            end
            S_ADD: begin
                if (r_phase == PH_HALF) r_mid <= add_res.value;
                if (add_res.clamp) r_flag <= 1'b1;
            end
            S_DONE: begin
                if (out_load) begin
                    for (int k = 0; k < 3; k++) begin
                        r_out_angle[k] <= fin_angle[k];
                        r_out_spin[k]  <= fin_spin[k];
                    end
                    r_out_sat <= r_flag;
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.angle_x   = r_out_angle[0];
    assign o_res.angle_y   = r_out_angle[1];
    assign o_res.angle_z   = r_out_angle[2];
    assign o_res.spin_x    = r_out_spin[0];
    assign o_res.spin_y    = r_out_spin[1];
    assign o_res.spin_z    = r_out_spin[2];
    assign o_res.saturated = r_out_sat;

`ifndef NO_ASSERTIONS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer |=> !i_cmd.ready)
        else $error("input accepted again while an item is in progress");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised before the sequence finished");

    a_div_ovf_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) && r_div_ovf && !r_zero |=> r_flag)
        else $error("overflowing acceleration did not raise the clamp flag");

    a_dt_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer |=> (r_dt == $past(i_cmd.step_time)))
        else $error("time step not captured on input transfer");
`endif

endmodule

// ===== tb/tb_rigid_body_rk2_step.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the three-axis midpoint integrator: directed and random steps.
module tb_rigid_body_rk2_step;
    import rbrk2_pkg::*;

    // The block is built with its default axis count, so all three axes integrate.
    localparam int AXES = 3;
    // Cycles from an input transfer to the result register.
    localparam int STEP_CYCLES = 41 * AXES + 1;
    // The limit lies far above the slowest correct run, which leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 125;
    localparam int PHASE_COUNT = 6;

    // Index 3 is reachable on the 2-bit port but names no register.
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    localparam t_torque TORQUE_MAX = 32'sh7FFF_FFFF;
    localparam t_torque TORQUE_MIN = 32'sh8000_0000;
    localparam t_word   STEP_MAX   = 32'hFFFF_FFFF;
    localparam t_word   STEP_ONE   = 32'h0100_0000;

    typedef struct packed {
        t_torque torque_x;
        t_torque torque_y;
        t_torque torque_z;
        t_word   step_time;
    } t_step_cmd;

    typedef struct packed {
        t_state angle_x;
        t_state angle_y;
        t_state angle_z;
        t_state spin_x;
        t_state spin_y;
        t_state spin_z;
        logic   saturated;
    } t_step_res;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_word    i_cfg_data;

    rbrk2_in_if  cmd_ch ();
    rbrk2_out_if res_ch ();

    rigid_body_rk2_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Steps waiting to be offered, and integrator states waiting to come back.
    t_step_cmd   pending_steps   [$];
    t_step_res   expected_states [$];
    t_step_cmd   next_step;
    t_step_res   oldest_state;

    // Our own copy of the integrator: inertia registers and per-axis state.
    t_word       inertia_now [AXES];
    t_state      angle_now   [AXES];
    t_state      spin_now    [AXES];
    bit          clamp_hit;

    bit          steady_flow;
    int          error_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Applies a sign to a magnitude and clamps it to the signed Q16.32 range.
    function automatic t_state limit_signed(bit neg, logic [127:0] mag);
        if (neg) begin
            if (mag > 128'h8000_0000_0000) begin
                clamp_hit = 1'b1;
                return STATE_MIN;
            end
            return t_state'(48'd0 - mag[47:0]);
        end
        if (mag > 128'h7FFF_FFFF_FFFF) begin
            clamp_hit = 1'b1;
            return STATE_MAX;
        end
        return t_state'(mag[47:0]);
    endfunction

    function automatic t_state sat_add(t_state a, t_state b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(STATE_MAX)) begin
            clamp_hit = 1'b1;
            return STATE_MAX;
        end
        if (s < longint'(STATE_MIN)) begin
            clamp_hit = 1'b1;
            return STATE_MIN;
        end
        return t_state'(s);
    endfunction

    // Exact product with the time step, then a rounded shift (24 for dt, 25 for dt/2).
    // Rounding is to nearest with ties away from zero, done on the magnitude.
    function automatic t_state scale_dt(t_state v, t_word dt, int unsigned sh);
        bit           neg;
        logic [127:0] mag;
        logic [127:0] prod;
        neg  = v < 0;
        mag  = neg ? 128'(-longint'(v)) : 128'(longint'(v));
        prod = mag * 128'(dt) + (128'd1 << (sh - 1));
        return limit_signed(neg, prod >> sh);
    endfunction

    // Acceleration in Q16.32: |torque| * 2^32 / inertia, rounded, sign restored.
    function automatic t_state torque_to_accel(t_torque t, t_word inertia);
        bit           neg;
        logic [127:0] mag;
        neg = t < 0;
        mag = neg ? 128'(-longint'(t)) : 128'(longint'(t));
        if (mag == 0) begin
            return '0;
        end
        // Zero inertia drives the acceleration to the rail in the torque's direction.
        if (inertia == 0) begin
            clamp_hit = 1'b1;
            return neg ? STATE_MIN : STATE_MAX;
        end
        return limit_signed(neg, ((mag << 32) + 128'(inertia >> 1)) / 128'(inertia));
    endfunction

    // One midpoint step on all axes; updates the predicted state and returns it.
    function automatic t_step_res rk2_advance(t_torque tx, t_torque ty, t_torque tz,
                                              t_word dt);
        t_torque   torque [AXES];
        t_state    accel;
        t_state    mid;
        t_step_res res;
        int        ax;
        torque[0] = tx;
        torque[1] = ty;
        torque[2] = tz;
        clamp_hit = 1'b0;
        for (ax = 0; ax < AXES; ax++) begin
            accel         = torque_to_accel(torque[ax], inertia_now[ax]);
            mid           = sat_add(spin_now[ax], scale_dt(accel, dt, 25));
            angle_now[ax] = sat_add(angle_now[ax], scale_dt(mid, dt, 24));
            spin_now[ax]  = sat_add(spin_now[ax], scale_dt(accel, dt, 24));
        end
        res.angle_x   = angle_now[0];
        res.angle_y   = angle_now[1];
        res.angle_z   = angle_now[2];
        res.spin_x    = spin_now[0];
        res.spin_y    = spin_now[1];
        res.spin_z    = spin_now[2];
        res.saturated = clamp_hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly small torques, which keep the state in range, with full-width values,
    // the two extremes, zero and tiny values mixed in.
    function automatic t_torque pick_torque();
        t_torque mag;
        bit      neg;
        neg = 1'($urandom_range(1));
        case ($urandom_range(9))
            0, 1, 2, 3: mag = t_torque'($urandom_range(32'h00FF_FFFF));
            4:          mag = t_torque'($urandom_range(32'h0FFF_FFFF));
            5, 6:       return t_torque'($urandom);
            7:          return neg ? TORQUE_MIN : TORQUE_MAX;
            8:          return '0;
            default:    mag = t_torque'($urandom_range(15));
        endcase
        return neg ? -mag : mag;
    endfunction

    // Mostly control-loop sized steps; zero, one second, full width and the ends too.
    function automatic t_word pick_step_time();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return t_word'($urandom_range(32'h0004_0000));
            5:             return '0;
            6:             return t_word'($urandom);
            7:             return t_word'($urandom_range(STEP_ONE));
            8:             return STEP_ONE;
            default:       return $urandom_range(1) ? STEP_MAX : t_word'(1);
        endcase
    endfunction

    task automatic queue_step(t_torque tx, t_torque ty, t_torque tz, t_word dt);
        pending_steps.push_back(t_step_cmd'{torque_x: tx, torque_y: ty, torque_z: tz,
                                            step_time: dt});
    endtask

    // A register write lands at the rising edge where the enable is seen high.
    task automatic write_reg(t_cfg_idx idx, t_word value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (int'(idx) < AXES) begin
            inertia_now[idx] = value;
        end
    endtask

    // Returns once every queued step has been transferred and its result checked,
    // and the block has had a full step time to settle. Sampled on the falling edge
    // so that no update of the same rising edge is missed.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_steps.size() != 0 || cmd_ch.valid || expected_states.size() != 0);
        repeat (STEP_CYCLES + 8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report_failure(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            report_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers queued steps on the command channel. Once valid is raised it
    // stays up with a stable payload until the transfer. A transfer is predicted
    // at the edge where it happens, so expectations stay in transfer order.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_ch.valid) begin
                expected_states.push_back(rk2_advance(cmd_ch.torque_x, cmd_ch.torque_y,
                                                      cmd_ch.torque_z, cmd_ch.step_time));
            end
            // Unless steady flow is set, the driver holds back a waiting step with a chance of nine in a hundred.
            if (pending_steps.size() != 0 && (steady_flow || $urandom_range(99) >= 9)) begin
                next_step = pending_steps.pop_front();
                cmd_ch.torque_x  <= next_step.torque_x;
                cmd_ch.torque_y  <= next_step.torque_y;
                cmd_ch.torque_z  <= next_step.torque_z;
                cmd_ch.step_time <= next_step.step_time;
                cmd_ch.valid     <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest expectation and
    // stalls the result channel at random unless steady flow is set.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_states.size() == 0) begin
                    report_failure("result transfer with no step outstanding");
                end else begin
                    oldest_state = expected_states.pop_front();
                    check_field("angle_x", oldest_state.angle_x, res_ch.angle_x);
                    check_field("angle_y", oldest_state.angle_y, res_ch.angle_y);
                    check_field("angle_z", oldest_state.angle_z, res_ch.angle_z);
                    check_field("spin_x", oldest_state.spin_x, res_ch.spin_x);
                    check_field("spin_y", oldest_state.spin_y, res_ch.spin_y);
                    check_field("spin_z", oldest_state.spin_z, res_ch.spin_z);
                    check_field("saturated", 48'(oldest_state.saturated),
                                48'(res_ch.saturated));
                end
            end
            res_ch.ready <= steady_flow || $urandom_range(99) >= 9;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        int phase;
        int ax;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_INERTIA_X;
        i_cfg_data       = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.torque_x  = '0;
        cmd_ch.torque_y  = '0;
        cmd_ch.torque_z  = '0;
        cmd_ch.step_time = '0;
        res_ch.ready     = 1'b0;
        steady_flow      = 1'b0;
        error_count      = 0;
        cycle_count      = 0;

        // Predictor state after reset: default inertias and zero attitude and rate.
        inertia_now[0] = INERTIA_X_RST;
        inertia_now[1] = INERTIA_Y_RST;
        inertia_now[2] = INERTIA_Z_RST;
        for (ax = 0; ax < AXES; ax++) begin
            angle_now[ax] = '0;
            spin_now[ax]  = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed steps at the reset inertias. A zero step time must leave the
        // state alone. The full-width steps drive every axis to the positive rails,
        // then across to the negative ones, which checks clamping of the products
        // and of the sums; the last steps bounce off the rails and exercise rounding.
        queue_step('0, '0, '0, '0);
        queue_step(TORQUE_MAX, TORQUE_MAX, TORQUE_MAX, '0);
        queue_step(TORQUE_MIN, TORQUE_MIN, TORQUE_MIN, '0);
        queue_step(32'sd1, -32'sd1, '0, 32'd1);
        queue_step(TORQUE_MAX, TORQUE_MIN, -32'sd1, 32'h0000_4000);
        queue_step(TORQUE_MIN, TORQUE_MAX, 32'sd1, STEP_ONE);
        queue_step(TORQUE_MAX, TORQUE_MAX, TORQUE_MAX, STEP_MAX);
        queue_step(TORQUE_MAX, TORQUE_MAX, TORQUE_MAX, STEP_MAX);
        queue_step('0, '0, '0, STEP_ONE);
        queue_step(TORQUE_MIN, TORQUE_MIN, TORQUE_MIN, STEP_MAX);
        queue_step(TORQUE_MIN, TORQUE_MIN, TORQUE_MIN, STEP_MAX);
        queue_step('0, '0, '0, STEP_MAX);
        queue_step(TORQUE_MAX, '0, TORQUE_MIN, STEP_MAX);
        queue_step('0, '0, '0, 32'd1);
        queue_step(32'sh0000_0100, -32'sd256, 32'sh0001_0000, 32'd2);
        queue_step(32'sh0028_F5C3, -32'sh0028_F5C3, 32'sh0014_7AE1, 32'h0002_8F5C);

        // Random phases, each under its own inertia setting. Registers change only
        // once the block has gone quiet.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(CFG_INERTIA_X, t_word'($urandom));
                    write_reg(CFG_INERTIA_Y, t_word'($urandom_range(32'h1000_0000,
                                                                    32'h0010_0000)));
                    write_reg(CFG_INERTIA_Z, t_word'($urandom_range(32'h0001_0000, 1)));
                    // A write to the unused index must change nothing.
                    write_reg(CFG_UNUSED, t_word'($urandom));
                end
                1: begin
                    // Smallest, largest and zero inertia.
                    write_reg(CFG_INERTIA_X, t_word'(1));
                    write_reg(CFG_INERTIA_Y, STEP_MAX);
                    write_reg(CFG_INERTIA_Z, '0);
                end
                2: begin
                    write_reg(CFG_INERTIA_X, INERTIA_X_RST);
                    write_reg(CFG_INERTIA_Y, INERTIA_Y_RST);
                    write_reg(CFG_INERTIA_Z, INERTIA_Z_RST);
                end
                3: begin
                    write_reg(CFG_INERTIA_X, t_word'($urandom_range(32'h0000_FFFF, 1)));
                    write_reg(CFG_INERTIA_Y, t_word'($urandom));
                    write_reg(CFG_INERTIA_Z, t_word'($urandom));
                    write_reg(CFG_UNUSED, '0);
                end
                4: begin
                    write_reg(CFG_INERTIA_X, '0);
                    write_reg(CFG_INERTIA_Y, t_word'(1));
                    write_reg(CFG_INERTIA_Z, STEP_MAX);
                end
                default: begin
                    write_reg(CFG_INERTIA_X, t_word'($urandom_range(32'h1000_0000,
                                                                    32'h0010_0000)));
                    write_reg(CFG_INERTIA_Y, t_word'($urandom_range(32'h1000_0000,
                                                                    32'h0010_0000)));
                    write_reg(CFG_INERTIA_Z, t_word'($urandom_range(32'h1000_0000,
                                                                    32'h0010_0000)));
                end
            endcase
            // Phase 2 runs without any idling on either side.
            steady_flow = (phase == 2);
            @(negedge i_clk);
            repeat (PHASE_ITEMS) begin
                queue_step(pick_torque(), pick_torque(), pick_torque(), pick_step_time());
            end
        end

        // Every expectation must be met; a result that never comes ends in the
        // cycle limit, and a stray one is caught during the final settle time.
        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
